/* src/chim_pkg.sv */
// Shared constants and types for the chained hash index map.
package chim_pkg;
  localparam int BUCKETS  = 256;
  localparam int CAPACITY = 512;
  localparam int BW = $clog2(BUCKETS);
  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);
  localparam logic [LW-1:0] LAST_STEP = LW'(CAPACITY - 1);

  localparam logic [1:0] FN_ADD  = 2'd0;
  localparam logic [1:0] FN_LOOK = 2'd1;
  localparam logic [1:0] FN_TAKE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]    func;
    logic [31:0]   key;
    logic [31:0]   value;
    logic [BW-1:0] bucket;
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HEAD  = 5'b00010,
    S_ALLOC = 5'b00100,
    S_WALK  = 5'b01000,
    S_FREE  = 5'b10000
  } state_t;
endpackage

/* src/chim_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module chim_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/chim_front.sv */
// Command intake: bucket classification and a two-deep command queue.
module chim_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic [31:0]         key,
  input  logic [31:0]         value,
  output logic                cmd_avail,
  output chim_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);
  import chim_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign cmd_avail = (count != 2'd0);
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{func: func, key: key, value: value, bucket: key[BW-1:0]};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end
endmodule

/* src/chim_back.sv */
// Operation engine: bucket lookup, chain walk, allocation and unlinking.
module chim_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_avail,
  input  chim_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           done,
  output logic [1:0]     status,
  output logic [31:0]    found_value
);
  import chim_pkg::*;

  state_t        state, state_next;
  cmd_t          cur_cmd;
  logic [LW-1:0] cur, cur_next;
  logic [LW-1:0] prev, prev_next;
  logic [LW-1:0] steps, steps_next;
  logic [LW-1:0] free_head, free_head_next;
  logic [LW-1:0] fresh, fresh_next;
  logic [BUCKETS-1:0] head_valid;
  logic          fin;
  logic [1:0]    fin_status;
  logic [31:0]   fin_value;

  logic          bh_we;
  logic [BW-1:0] bh_raddr;
  logic [LW-1:0] bh_wdata, bh_rdata, head;
  logic          ent_we, link_we;
  logic [IW-1:0] ent_waddr, link_waddr, ent_raddr;
  logic [LW-1:0] link_wdata, link_rdata;
  logic [31:0]   key_rdata, value_rdata;

  chim_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(bh_we), .waddr(cur_cmd.bucket), .wdata(bh_wdata),
    .raddr(bh_raddr), .rdata(bh_rdata));
  chim_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(cur_cmd.key),
    .raddr(ent_raddr), .rdata(key_rdata));
  chim_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_value (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(cur_cmd.value),
    .raddr(ent_raddr), .rdata(value_rdata));
  chim_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(ent_raddr), .rdata(link_rdata));

  assign head     = head_valid[cur_cmd.bucket] ? bh_rdata : NIL;
  assign bh_raddr = (state == S_IDLE) ? cmd.bucket : cur_cmd.bucket;

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    prev_next      = prev;
    steps_next     = steps;
    free_head_next = free_head;
    fresh_next     = fresh;
    cmd_pop        = 1'b0;
    fin            = 1'b0;
    fin_status     = ST_MISS;
    fin_value      = 32'd0;
    bh_we          = 1'b0;
    bh_wdata       = link_rdata;
    ent_we         = 1'b0;
    ent_waddr      = cur[IW-1:0];
    link_we        = 1'b0;
    link_waddr     = prev[IW-1:0];
    link_wdata     = link_rdata;
    ent_raddr      = cur[IW-1:0];
    case (state)
      S_IDLE: begin
        if (cmd_avail) begin
          cmd_pop    = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        case (cur_cmd.func)
          FN_ADD: begin
            if (free_head != NIL) begin
              cur_next   = free_head;
              ent_raddr  = free_head[IW-1:0];
              state_next = S_ALLOC;
            end else if (fresh != NIL) begin
              ent_we     = 1'b1;
              ent_waddr  = fresh[IW-1:0];
              link_we    = 1'b1;
              link_waddr = fresh[IW-1:0];
              link_wdata = head;
              bh_we      = 1'b1;
              bh_wdata   = fresh;
              fresh_next = fresh + 1'b1;
              fin        = 1'b1;
              fin_status = ST_OK;
              state_next = S_IDLE;
            end else begin
              fin        = 1'b1;
              fin_status = ST_FULL;
              state_next = S_IDLE;
            end
          end
          FN_LOOK, FN_TAKE: begin
            cur_next   = head;
            prev_next  = NIL;
            steps_next = '0;
            ent_raddr  = head[IW-1:0];
            if (head >= NIL) begin
              fin        = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_WALK;
            end
          end
          default: begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_ALLOC: begin
        free_head_next = link_rdata;
        ent_we         = 1'b1;
        link_we        = 1'b1;
        link_waddr     = cur[IW-1:0];
        link_wdata     = head;
        bh_we          = 1'b1;
        bh_wdata       = cur;
        fin            = 1'b1;
        fin_status     = ST_OK;
        state_next     = S_IDLE;
      end
      S_WALK: begin
        if (key_rdata == cur_cmd.key) begin
          fin_value = value_rdata;
          if (cur_cmd.func == FN_TAKE) begin
            if (prev != NIL) begin
              link_we = 1'b1;
            end else begin
              bh_we = 1'b1;
            end
            state_next = S_FREE;
          end else begin
            fin        = 1'b1;
            fin_status = ST_OK;
            state_next = S_IDLE;
          end
        end else begin
          prev_next  = cur;
          cur_next   = link_rdata;
          steps_next = steps + 1'b1;
          ent_raddr  = link_rdata[IW-1:0];
          if (link_rdata >= NIL || steps == LAST_STEP) begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_FREE: begin
        link_we        = 1'b1;
        link_waddr     = cur[IW-1:0];
        link_wdata     = free_head;
        free_head_next = cur;
        fin            = 1'b1;
        fin_status     = ST_OK;
        fin_value      = found_value;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur_cmd <= cmd;
    cur   <= cur_next;
    prev  <= prev_next;
    steps <= steps_next;
    if (fin) begin
      status <= fin_status;
    end
    if (fin || state == S_WALK) begin
      found_value <= fin_value;
    end
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= NIL;
      fresh      <= '0;
      head_valid <= '0;
      done       <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      done      <= fin;
      if (bh_we) head_valid[cur_cmd.bucket] <= 1'b1;
    end
  end
endmodule

/* src/chained_hash_index_map.sv */
// Top level of the chained hash index map.
// Usage:
//   Command channel: drive func, key, value and raise start; the command is
//   taken at a rising edge where start is high and busy is low. busy rises
//   when the two-deep command queue is full.
//   Result channel: done pulses for one cycle with status and found_value.
//   Results come in command order; the receiver cannot stall them.
// Sequencing:
//   With the queue empty, an add goes from S_IDLE through S_HEAD, where its
//   result is produced (reusing a freed entry adds S_ALLOC, which needs the
//   free-list link read). Look and take go through S_HEAD, then one S_WALK
//   step per chain entry visited, plus S_FREE for the take unlink. Queued
//   commands wait. The engine handles one command at a time; each step is
//   one registered read of the entry RAMs, which sets the rate.
// Reset:
//   rst clears the queue, all bucket valid bits, the free list and the
//   pool counter; no clearing pass is needed. done is low after reset.
module chained_hash_index_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] found_value
);
  import chim_pkg::*;

  logic cmd_avail;
  logic cmd_pop;
  cmd_t cmd;

  chim_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .key(key),
    .value(value), .cmd_avail(cmd_avail), .cmd(cmd), .cmd_pop(cmd_pop));

  chim_back u_back (
    .clk(clk), .rst(rst), .cmd_avail(cmd_avail), .cmd(cmd), .cmd_pop(cmd_pop),
    .done(done), .status(status), .found_value(found_value));
endmodule

/* src/chim_checker.sv */
// Port-level checks for the chained hash index map, bound to the top level.
module chim_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] found_value
);
  import chim_pkg::*;

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
    else $error("illegal status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (found_value == 32'd0))
    else $error("nonzero value on failed command");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!done && !busy))
    else $error("activity right after reset");

  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    $past(!start, 1) && $past(!start, 2) && $past(!busy, 1) && $past(!done, 1)
      && $past(!busy, 2) && $past(rst, 2) |-> !done)
    else $error("result without command");
endmodule

bind chained_hash_index_map chim_checker u_chim_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .found_value(found_value));

/* bench/tb_chained_hash_index_map.sv */
// Self-checking testbench for chained_hash_index_map: add/look/take traffic with pool exhaustion.
module tb_chained_hash_index_map;
  timeunit 1ns;
  timeprecision 1ps;
  import chim_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [1:0] FN_RESERVED = 2'd3;
  localparam int KEY_POOL = 48;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
    bit          drain;
  } map_cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
  } map_answer_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  func = '0;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic        done;
  logic [1:0]  status;
  logic [31:0] found_value;

  chained_hash_index_map u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .key(key),
    .value(value), .done(done), .status(status), .found_value(found_value)
  );

  map_cmd_t    cmd_queue[$];
  map_answer_t awaited_answers[$];
  logic [31:0] key_pool[KEY_POOL];
  int          errors = 0;
  int          cycles = 0;
  int          accepted = 0;
  bit          took = 0;

  logic [LW-1:0] chain_head[BUCKETS];
  logic [31:0]   slot_key[CAPACITY];
  logic [31:0]   slot_value[CAPACITY];
  logic [LW-1:0] slot_next[CAPACITY];
  logic [LW-1:0] spare_head;
  int            fresh_used;

  initial forever #5 clk = ~clk;

  function automatic map_answer_t apply_map_op(logic [1:0] op, logic [31:0] k, logic [31:0] v);
    map_answer_t   ans;
    int            b;
    logic [LW-1:0] cur, prev, e;
    bit            hit;
    ans.status = ST_MISS;
    ans.value = '0;
    b = k % BUCKETS;
    if (op == FN_ADD) begin
      e = NIL;
      if (spare_head < NIL) begin
        e = spare_head;
        spare_head = slot_next[e];
      end else if (fresh_used < CAPACITY) begin
        e = LW'(fresh_used);
        fresh_used++;
      end
      if (e < NIL) begin
        slot_key[e] = k;
        slot_value[e] = v;
        slot_next[e] = chain_head[b];
        chain_head[b] = e;
        ans.status = ST_OK;
      end else begin
        ans.status = ST_FULL;
      end
    end else if (op == FN_LOOK || op == FN_TAKE) begin
      cur = chain_head[b];
      prev = NIL;
      hit = 0;
      for (int s = 0; s < CAPACITY && !hit && cur < NIL; s++) begin
        if (slot_key[cur] == k) begin
          hit = 1;
        end else begin
          prev = cur;
          cur = slot_next[cur];
        end
      end
      if (hit) begin
        ans.status = ST_OK;
        ans.value = slot_value[cur];
        if (op == FN_TAKE) begin
          if (prev < NIL) slot_next[prev] = slot_next[cur];
          else chain_head[b] = slot_next[cur];
          slot_next[cur] = spare_head;
          spare_head = cur;
        end
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    map_answer_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else if (!rst) begin
      if (start && !busy) begin
        awaited_answers.push_back(apply_map_op(func, key, value));
        accepted++;
        took = 1;
      end
      if (done) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("unexpected transaction", '0, {30'd0, status});
        end else begin
          want = awaited_answers.pop_front();
          if (status !== want.status) report_mismatch("status", want.status, status);
          if (found_value !== want.value) report_mismatch("found_value", want.value, found_value);
        end
      end
    end
  end

  always @(negedge clk) begin
    logic     next_start;
    int       idle_pct;
    map_cmd_t c;
    next_start = start && !took;
    took = 0;
    if (!rst && !next_start && cmd_queue.size() > 0) begin
      idle_pct = accepted < 650 ? 32 : accepted < 1300 ? 59 : 0;
      if (!(cmd_queue[0].drain && awaited_answers.size() > 0) &&
          $urandom_range(99) >= idle_pct) begin
        c = cmd_queue.pop_front();
        func <= c.func;
        key <= c.key;
        value <= c.value;
        next_start = 1;
      end
    end
    start <= next_start;
  end

  task automatic queue_cmd(logic [1:0] op, logic [31:0] k, logic [31:0] v, bit drain = 0);
    map_cmd_t c;
    c.func = op;
    c.key = k;
    c.value = v;
    c.drain = drain;
    cmd_queue.push_back(c);
  endtask

  task automatic queue_random(int n, int add_pct, int look_pct, int take_pct);
    int          r;
    logic [1:0]  op;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      op = r < add_pct ? FN_ADD : r < add_pct + look_pct ? FN_LOOK :
           r < add_pct + look_pct + take_pct ? FN_TAKE : FN_RESERVED;
      k = $urandom_range(9) == 0 ? $urandom() : key_pool[$urandom_range(KEY_POOL - 1)];
      queue_cmd(op, k, $urandom(), i == n / 2);
    end
  endtask

  initial begin
    for (int b = 0; b < BUCKETS; b++) chain_head[b] = NIL;
    for (int e = 0; e < CAPACITY; e++) begin
      slot_key[e] = '0;
      slot_value[e] = '0;
      slot_next[e] = '0;
    end
    spare_head = NIL;
    fresh_used = 0;
    for (int i = 0; i < KEY_POOL; i++)
      key_pool[i] = {$urandom_range(3) == 0 ? 24'hFFFFFF : 24'($urandom()),
                     8'($urandom_range(7) * 37)};

    queue_cmd(FN_ADD, 32'h0, 32'h0);
    queue_cmd(FN_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_cmd(FN_LOOK, 32'h0, 32'h5A5A5A5A);
    queue_cmd(FN_LOOK, 32'hFFFFFFFF, 32'h0);
    queue_cmd(FN_TAKE, 32'hFFFFFFFF, 32'h0);
    queue_cmd(FN_LOOK, 32'hFFFFFFFF, 32'h0);
    queue_cmd(FN_ADD, 32'd5, 32'h11111111);
    queue_cmd(FN_ADD, 32'd5, 32'h22222222);
    queue_cmd(FN_ADD, 32'd261, 32'h33333333);
    queue_cmd(FN_ADD, 32'd517, 32'h44444444);
    queue_cmd(FN_LOOK, 32'd5, 32'h0);
    queue_cmd(FN_TAKE, 32'd5, 32'h0);
    queue_cmd(FN_LOOK, 32'd5, 32'h0);
    queue_cmd(FN_TAKE, 32'd261, 32'h0);
    queue_cmd(FN_TAKE, 32'd5, 32'h0);
    queue_cmd(FN_TAKE, 32'd5, 32'h0);
    queue_cmd(FN_RESERVED, 32'd517, 32'hFFFFFFFF);
    queue_cmd(FN_ADD, 32'h80000000, 32'hDEADBEEF);
    queue_cmd(FN_LOOK, 32'd517, 32'h0);
    queue_cmd(FN_TAKE, 32'h0, 32'h0, 1);

    queue_random(500, 40, 30, 25);
    queue_random(600, 95, 3, 0);
    queue_random(850, 15, 30, 50);

    repeat (5) @(posedge clk);
    rst <= 0;
    wait (cmd_queue.size() == 0 && !start);
    wait (awaited_answers.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0 && awaited_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* files.f */
src/chim_pkg.sv
src/chim_ram.sv
src/chim_front.sv
src/chim_back.sv
src/chained_hash_index_map.sv
src/chim_checker.sv
bench/tb_chained_hash_index_map.sv
